### sv/mwo_pkg.sv
// Package for the morphing waveform oscillator.
// Holds the sequencer state type, the arithmetic constants and the tanh table
// builder. No dependencies.
package mwo_pkg;

	// Sequencer steps, one-hot.
	typedef enum logic [16:0] {
		ST_IDLE   = 17'b00000000000000001,
		ST_RNG    = 17'b00000000000000010,
		ST_INC    = 17'b00000000000000100,
		ST_JIT    = 17'b00000000000001000,
		ST_TRI    = 17'b00000000000010000,
		ST_T2     = 17'b00000000000100000,
		ST_INNER  = 17'b00000000001000000,
		ST_MID    = 17'b00000000010000000,
		ST_W1     = 17'b00000000100000000,
		ST_W2     = 17'b00000001000000000,
		ST_MIX    = 17'b00000010000000000,
		ST_SCALE  = 17'b00000100000000000,
		ST_IDX    = 17'b00001000000000000,
		ST_ROM    = 17'b00010000000000000,
		ST_INTERP = 17'b00100000000000000,
		ST_NOISE  = 17'b01000000000000000,
		ST_OUT    = 17'b10000000000000000
	} mwo_state_t;

	localparam logic [31:0] SCALE_RESET = 32'd22906492;
	localparam logic [24:0] LCG_MUL     = 25'd1664525;
	localparam logic [31:0] LCG_ADD     = 32'd1013904223;
	localparam logic [24:0] JIT_GAIN    = 25'd687195;
	localparam logic [24:0] NOISE_GAIN  = 25'd26844;
	localparam logic [24:0] SIN_C3      = 25'd5217;
	localparam logic [16:0] SIN_C2      = 17'd42336;
	localparam logic [16:0] SIN_C1      = 17'd102944;
	localparam longint unsigned ONE_Q24 = 64'd16777216;

	// Unsigned quotient by shift and subtract, used while the table is built.
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// One table entry: tanh(2.1*i/depth) in Q16 from an exp series in Q24.
	function automatic logic [15:0] tanh_entry(input longint unsigned depth,
		input longint unsigned i);
		longint unsigned den;
		longint unsigned z;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned res;
		longint unsigned k;
		den  = 64'd5 * depth;
		z    = udiv(i * 64'd21 * ONE_Q24 + (den >> 1), den);
		term = ONE_Q24;
		sum  = ONE_Q24;
		for (k = 1; k < 64; k++) begin
			if (term != 0) begin
				term = udiv((term * z) >> 24, k);
				sum  = sum + term;
			end
		end
		res = udiv((sum - ONE_Q24) * 64'd65536 + ((sum + ONE_Q24) >> 1), sum + ONE_Q24);
		return res[15:0];
	endfunction

endpackage

### sv/mwo_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing but the clock.
module mwo_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [24:0] b,
	output logic signed [57:0] p_q
);

	// One product per cycle, available the cycle after the operands.
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

### sv/mwo_tanh_rom.sv
// Tanh shaper table with two registered read ports (entry and its neighbor).
// Uses tanh_entry from mwo_pkg to build its contents at elaboration.
module mwo_tanh_rom import mwo_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] addr,
	output logic [15:0]   lo_q,
	output logic [15:0]   hi_q
);

	typedef logic [15:0] rom_t [DEPTH+1];

	function automatic rom_t build_table();
		rom_t tab;
		for (int i = 0; i <= DEPTH; i++) begin
			tab[i] = tanh_entry(longint'(DEPTH), longint'(i));
		end
		return tab;
	endfunction

	localparam rom_t TANH_TAB = build_table();

	// The address never exceeds DEPTH-1, so the neighbor stays in range.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_q <= TANH_TAB[addr];
			hi_q <= TANH_TAB[addr + AW'(1)];
		end
	end

endmodule

### sv/morphing_waveform_oscillator_core.sv
// Morphing waveform oscillator top level: sequencer, state and datapath.
// Uses mwo_pkg, mwo_mul and mwo_tanh_rom.
//
// channel | direction | word
// s       | in        | s_tdata[23:0] freq_q8, s_tdata[40:24] shape_q16
// m       | out       | m_tdata[15:0] sample
// cfg     | in        | cfg_data[31:0] hz_to_phase_scale
//
// Each accepted word passes through the sequencer steps from RNG to OUT before
// a valid output word appears, and no new word is taken until the sequencer is
// idle again; the shared 33x25 multiplier gives at most one product per step.
// s_tready is high only while the sequencer is idle.
// A held output stalls the last step until the register is free.
// Reset clears the phase, the noise word and restores the scale register.
module morphing_waveform_oscillator_core import mwo_pkg::*; #(
	parameter int TANH_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [23:0] freq_q8, [40:24] shape_q16, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);

	mwo_state_t state_q;
	logic [31:0] scale_q, rng_q, phase_q, inc_q;
	logic [23:0] freq_q;
	logic [16:0] shape_q, t2_q, ax_q, frac_q;
	logic signed [17:0] tri_q, saw_q, y_q;
	logic signed [57:0] acc_q;
	logic neg_q;
	logic out_valid_q;
	logic [15:0] out_q;

	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [57:0] p_q;
	logic [15:0] lo_q, hi_q;

	logic signed [17:0] tri_c, saw_c, sine_c, sel1_c, sel2_c;
	logic signed [18:0] tri19_c;
	logic [16:0] shape_in, inner_c, mid_c, t_c, w1_c, shm_c;
	logic low_c;
	logic signed [57:0] sum_c;
	logic signed [18:0] mix_c, amix_c;
	logic [15:0] diff_c;
	logic [16:0] ymag_c;
	logic [33:0] pround_c;
	logic signed [18:0] v_c;
	logic signed [17:0] half_c;
	logic [15:0] sat_c;
	logic in_acc, out_acc;

	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// Shape saturates at one on the way in.
	assign shape_in = (s_tdata[40:24] > 17'd65536) ? 17'd65536 : s_tdata[40:24];

	// Waveforms from the phase.
	always_comb begin
		tri19_c = 19'sd196608 - $signed({1'b0, phase_q[31:14]});
		if (!phase_q[31]) begin
			tri_c = $signed({1'b0, phase_q[30:14]}) - 18'sd65536;
		end else begin
			tri_c = tri19_c[17:0];
		end
		saw_c = $signed({1'b0, phase_q[31:15]}) - 18'sd65536;
	end

	// Polynomial and crossfade terms.
	always_comb begin
		inner_c = SIN_C2 - p_q[32:16];
		mid_c   = SIN_C1 - p_q[32:16];
		sine_c  = p_q[33:16];
		low_c   = (shape_q[16:15] == 2'b00);
		shm_c   = shape_q - 17'd32768;
		t_c     = low_c ? {shape_q[15:0], 1'b0} : {shm_c[15:0], 1'b0};
		w1_c    = 17'd65536 - t_c;
		sel1_c  = low_c ? sine_c : tri_q;
		sel2_c  = low_c ? tri_q : saw_q;
		sum_c   = acc_q + p_q;
		mix_c   = sum_c[34:16];
		amix_c  = mix_c[18] ? -mix_c : mix_c;
	end

	// Interpolation and output saturation.
	always_comb begin
		diff_c   = (hi_q >= lo_q) ? (hi_q - lo_q) : (lo_q - hi_q);
		pround_c = p_q[33:0] + 34'h1FFFF;
		if (hi_q >= lo_q) begin
			ymag_c = {1'b0, lo_q} + p_q[33:17];
		end else begin
			ymag_c = {1'b0, lo_q} - pround_c[33:17];
		end
		v_c    = {y_q[17], y_q} + {{11{p_q[47]}}, p_q[47:40]};
		half_c = v_c[18:1];
		if (half_c > 18'sd32767) begin
			sat_c = 16'h7FFF;
		end else if (half_c < -18'sd32768) begin
			sat_c = 16'h8000;
		end else begin
			sat_c = half_c[15:0];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				mul_a = {1'b0, rng_q};
				mul_b = LCG_MUL;
			end
			ST_RNG: begin
				mul_a = {1'b0, scale_q};
				mul_b = {freq_q[23], freq_q};
			end
			ST_INC: begin
				mul_a = {rng_q[31], rng_q};
				mul_b = JIT_GAIN;
			end
			ST_TRI: begin
				mul_a = {{15{tri_c[17]}}, tri_c};
				mul_b = {{7{tri_c[17]}}, tri_c};
			end
			ST_T2: begin
				mul_a = {16'b0, p_q[32:16]};
				mul_b = SIN_C3;
			end
			ST_INNER: begin
				mul_a = {16'b0, t2_q};
				mul_b = {8'b0, inner_c};
			end
			ST_MID: begin
				mul_a = {{15{tri_q[17]}}, tri_q};
				mul_b = {8'b0, mid_c};
			end
			ST_W1: begin
				mul_a = {{15{sel1_c[17]}}, sel1_c};
				mul_b = {8'b0, w1_c};
			end
			ST_W2: begin
				mul_a = {{15{sel2_c[17]}}, sel2_c};
				mul_b = {8'b0, t_c};
			end
			ST_SCALE: begin
				mul_a = {16'b0, ax_q};
				mul_b = 25'(TANH_TABLE_DEPTH);
			end
			ST_ROM: begin
				mul_a = {17'b0, diff_c};
				mul_b = {8'b0, frac_q};
			end
			// The noise product is held until the output word is loaded.
			ST_INTERP, ST_NOISE, ST_OUT: begin
				mul_a = {rng_q[31], rng_q};
				mul_b = NOISE_GAIN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	mwo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	mwo_tanh_rom #(
		.DEPTH (TANH_TABLE_DEPTH),
		.AW    (AW)
	) u_rom (
		.clk   (clk),
		.rd_en (state_q == ST_IDX),
		.addr  (p_q[17 +: AW]),
		.lo_q  (lo_q),
		.hi_q  (hi_q)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= SCALE_RESET;
			rng_q       <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				scale_q <= cfg_data;
			end
			if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_RNG;
				end
				ST_RNG: begin
					rng_q   <= p_q[31:0] + LCG_ADD;
					state_q <= ST_INC;
				end
				ST_INC:    state_q <= ST_JIT;
				ST_JIT: begin
					phase_q <= phase_q + inc_q + {{6{p_q[57]}}, p_q[57:32]};
					state_q <= ST_TRI;
				end
				ST_TRI:    state_q <= ST_T2;
				ST_T2:     state_q <= ST_INNER;
				ST_INNER:  state_q <= ST_MID;
				ST_MID:    state_q <= ST_W1;
				ST_W1:     state_q <= ST_W2;
				ST_W2:     state_q <= ST_MIX;
				ST_MIX:    state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_IDX;
				ST_IDX:    state_q <= ST_ROM;
				ST_ROM:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_NOISE;
				ST_NOISE:  state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					freq_q  <= s_tdata[23:0];
					shape_q <= shape_in;
				end
			end
			ST_INC:    inc_q <= p_q[47:16];
			ST_TRI: begin
				tri_q <= tri_c;
				saw_q <= saw_c;
			end
			ST_T2:     t2_q  <= p_q[32:16];
			ST_W2:     acc_q <= p_q;
			ST_MIX: begin
				neg_q <= mix_c[18];
				ax_q  <= (amix_c > 19'sd131071) ? 17'h1FFFF : amix_c[16:0];
			end
			ST_IDX:    frac_q <= p_q[16:0];
			ST_INTERP: y_q <= neg_q ? -$signed({1'b0, ymag_c}) : $signed({1'b0, ymag_c});
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= sat_c;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/mwo_checker.sv
// Port-level checker for the oscillator core, bound to the top level.
// Uses only the top level's ports.
module mwo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        cfg_ready
);

	// A held word keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// After an accepted word the core stays busy before it accepts another.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input accepted again too early");

	// A result does not appear right after acceptance into an empty output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
		else $error("result appeared too early");

	// The register port never stalls.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind morphing_waveform_oscillator_core mwo_checker u_mwo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);

### test/tb_morphing_waveform_oscillator_core.sv
// Testbench for morphing_waveform_oscillator_core: drives frequency/shape words,
// predicts each sample with a local fixed-point model and checks the output stream.
// Depends on the RTL top level and mwo_pkg.
module tb_morphing_waveform_oscillator_core import mwo_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 1024;
	localparam int FREQ_MAX    = 6144000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;    // [23:0] freq_q8, [40:24] shape_q16, rest zero
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [15:0] sample
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// Model state: phase, noise word, scale register and the tanh table.
	logic [31:0]     phase_word;
	logic [31:0]     noise_word;
	logic [31:0]     scale_reg;
	longint unsigned tanh_q16 [0:TABLE_DEPTH];

	logic [15:0] pending_samples [$];
	int          error_count = 0;
	bit          tx_idle_on  = 1'b1;
	bit          rx_idle_on  = 1'b1;
	int          rx_hold     = 0;

	morphing_waveform_oscillator_core #(.TANH_TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Fill the table with tanh(2.1*i/depth) from an exp series in Q24.
	task automatic fill_tanh_table();
		longint unsigned one, den, z, term, acc;
		one = 64'd16777216;
		den = 64'd5 * TABLE_DEPTH;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			z = (longint'(i) * 64'd21 * one + den / 2) / den;
			term = one;
			acc = one;
			for (int k = 1; k < 64 && term != 0; k++) begin
				term = ((term * z) >> 24) / k;
				acc = acc + term;
			end
			tanh_q16[i] = ((acc - one) * 64'd65536 + (acc + one) / 2) / (acc + one);
		end
	endtask

	// Advance the oscillator by one sample and return the expected Q1.15 value.
	function automatic logic [15:0] next_sample(logic signed [23:0] freq, logic [16:0] shape);
		longint r, inc, jit, tri_v, t2, inner, mid, sine, saw, mix, t, y, v, ax;
		longint prod, idx, frac, lo, hi, s;
		noise_word = noise_word * 32'd1664525 + 32'd1013904223;
		r = longint'($signed(noise_word));
		inc = (longint'(freq) * longint'(scale_reg)) >>> 16;
		jit = (r * 687195) >>> 32;
		phase_word = phase_word + 32'(inc + jit);
		if (phase_word < 32'h8000_0000)
			tri_v = longint'(phase_word >> 14) - 65536;
		else
			tri_v = 196608 - longint'(phase_word >> 14);
		t2 = (tri_v * tri_v) >>> 16;
		inner = 42336 - ((t2 * 5217) >>> 16);
		mid = 102944 - ((t2 * inner) >>> 16);
		sine = (tri_v * mid) >>> 16;
		saw = longint'(phase_word >> 15) - 65536;
		s = (shape > 17'd65536) ? 65536 : longint'(shape);
		if (s < 32768) begin
			t = 2 * s;
			mix = (sine * (65536 - t) + tri_v * t) >>> 16;
		end else begin
			t = 2 * (s - 32768);
			mix = (tri_v * (65536 - t) + saw * t) >>> 16;
		end
		// Odd-symmetric interpolated table lookup, argument clamped below 2.0.
		ax = (mix < 0) ? -mix : mix;
		if (ax > 131071)
			ax = 131071;
		prod = ax * TABLE_DEPTH;
		idx = prod >>> 17;
		frac = prod & 131071;
		lo = longint'(tanh_q16[idx]);
		hi = longint'(tanh_q16[idx + 1]);
		if (hi >= lo)
			y = lo + (((hi - lo) * frac) >>> 17);
		else
			y = lo - (((lo - hi) * frac + 131071) >>> 17);
		if (mix < 0)
			y = -y;
		v = (y + ((r * 26844) >>> 40)) >>> 1;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	// Offer one word; the expectation is recorded at the handshake.
	task automatic send_word(logic signed [23:0] freq, logic [16:0] shape);
		while (tx_idle_on && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, shape, freq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_samples.push_back(next_sample(freq, shape));
	endtask

	// Write the scale register once the output stream has drained.
	task automatic write_scale(logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		scale_reg = value;
	endtask

	function automatic logic signed [23:0] rand_freq();
		if ($urandom_range(1))
			return 24'($signed($urandom_range(2 * FREQ_MAX)) - FREQ_MAX);
		return 24'($signed($urandom_range(400000)) - 200000);
	endfunction

	function automatic logic [16:0] rand_shape();
		if ($urandom_range(9) < 7)
			return 17'($urandom_range(65536));
		return 17'($urandom);
	endfunction

	// Extremes of frequency and every region of the shape morph.
	task automatic test_directed();
		logic [16:0] shapes [6] = '{17'd0, 17'd32767, 17'd32768, 17'd65535, 17'd65536,
			17'd131071};
		logic signed [23:0] freqs [4] = '{-24'sd6144000, 24'sd6144000, 24'sd0, -24'sd1};
		foreach (shapes[i])
			send_word(freqs[i % 4], shapes[i]);
		foreach (freqs[i])
			send_word(freqs[i], 17'd65536 - 17'(i * 16384));
		send_word(24'sd1, 17'd100000);
		send_word(24'sd112640, 17'd16384);
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_word(rand_freq(), rand_shape());
	endtask

	// Output held off for a long stretch while input keeps coming.
	task automatic test_backpressure();
		rx_hold = 300;
		test_random(40);
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random(120);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receive side: random stalls, long hold-off, and the check of each sample.
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample, actual %0d", $realtime, $signed(m_tdata));
				error_count++;
			end else begin
				want = pending_samples.pop_front();
				if (want !== m_tdata) begin
					$display("%0t: sample mismatch, expected %0d, actual %0d", $realtime,
						$signed(want), $signed(m_tdata));
					error_count++;
				end
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(rx_idle_on && $urandom_range(99) < 27);
		end
	end

	initial begin
		#2_000_000;
		$display("tb_morphing_waveform_oscillator_core: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		phase_word = '0;
		noise_word = '0;
		scale_reg = SCALE_RESET;
		fill_tanh_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150);
		test_backpressure();
		write_scale(32'd1);
		test_directed();
		test_random(60);
		write_scale(32'hFFFF_FFFF);
		test_directed();
		test_random(60);
		write_scale($urandom);
		test_full_rate();
		write_scale(SCALE_RESET);
		test_random(100);

		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("tb_morphing_waveform_oscillator_core: PASS");
		else
			$display("tb_morphing_waveform_oscillator_core: FAIL");
		$finish;
	end

endmodule
